// ===== hw/rtl/set_pkg.sv =====
// Shared types and constants for the Sobel edge threshold block.
// No dependencies.
`timescale 1ns / 1ps

package set_pkg;

    localparam int PIX_W  = 10;
    localparam int CFG_DW = 11;
    localparam int CFG_IW = 2;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int FIFO_CW    = 4;

    localparam logic [PIX_W-1:0] FULL_SCALE = 10'd765;
    localparam logic [11:0] SLOPE_STEEP_P1   = 12'd2473;
    localparam logic [11:0] SLOPE_SHALLOW_P1 = 12'd415;

    localparam logic [CFG_DW-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_DW-1:0] HEIGHT_RESET = 11'd480;

    typedef logic [PIX_W-1:0] t_pix;
    typedef t_pix [8:0] t_win;

    typedef enum logic [CFG_IW-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_LOW    = 2'd2,
        CFG_HIGH   = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DIR_0   = 2'd0,
        DIR_45  = 2'd1,
        DIR_90  = 2'd2,
        DIR_135 = 2'd3
    } t_dir;

    typedef struct packed {
        logic emit;
        logic border;
        logic last;
    } t_tag;

    typedef struct packed {
        t_pix value;
        logic last;
    } t_res;

endpackage

// ===== hw/rtl/set_if.sv =====
// Handshake interfaces for pixel input, result output and configuration.
// Depends on set_pkg.
`timescale 1ns / 1ps

interface set_pix_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [9:0]  pixel_value;
    modport source (output valid, output action, output pixel_value, input ready);
    modport sink   (input valid, input action, input pixel_value, output ready);
endinterface

interface set_res_if;
    logic        valid;
    logic        ready;
    logic [9:0]  edge_value;
    logic        frame_last;
    modport source (output valid, output edge_value, output frame_last, input ready);
    modport sink   (input valid, input edge_value, input frame_last, output ready);
endinterface

interface set_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [set_pkg::CFG_IW-1:0]    index;
    logic [set_pkg::CFG_DW-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/set_line_buf.sv =====
// Two row memories with registered reads and the 3x3 window.
// Depends on set_pkg.
`timescale 1ns / 1ps

module set_line_buf #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_pix,
    input  logic [AW-1:0]     i_col,
    input  set_pkg::t_pix     i_px,
    input  set_pkg::t_tag     i_tag,
    output set_pkg::t_win     o_win,
    output set_pkg::t_tag     o_tag
);

    set_pkg::t_pix mem_up  [DEPTH];
    set_pkg::t_pix mem_mid [DEPTH];

    set_pkg::t_pix r_up_rd;
    set_pkg::t_pix r_mid_rd;
    logic          r_s1_pix;
    logic [AW-1:0] r_s1_col;
    set_pkg::t_pix r_s1_px;
    set_pkg::t_tag r_s1_tag;
    set_pkg::t_tag r_s2_tag;
    set_pkg::t_win r_win;
    set_pkg::t_win n_win;

    always_ff @(posedge i_clk) begin
        if (i_pix) begin
            r_up_rd  <= mem_up[i_col];
            r_mid_rd <= mem_mid[i_col];
        end
        if (r_s1_pix) begin
            mem_up[r_s1_col]  <= r_mid_rd;
            mem_mid[r_s1_col] <= r_s1_px;
        end
    end

    always_comb begin
        n_win = r_win;
        if (r_s1_pix) begin
            for (int k = 0; k < 3; k++) begin
                n_win[k*3+0] = r_win[k*3+1];
                n_win[k*3+1] = r_win[k*3+2];
            end
            n_win[2] = r_up_rd;
            n_win[5] = r_mid_rd;
            n_win[8] = r_s1_px;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_col <= i_col;
        r_s1_px  <= i_px;
        if (!i_rst_n) begin
            r_s1_pix <= 1'b0;
            r_s1_tag <= '0;
            r_s2_tag <= '0;
            r_win    <= '0;
        end else begin
            r_s1_pix <= i_pix;
            r_s1_tag <= i_tag;
            r_s2_tag <= r_s1_tag;
            r_win    <= n_win;
        end
    end

    assign o_win = r_win;
    assign o_tag = r_s2_tag;

endmodule

// ===== hw/rtl/set_classify.sv =====
// Sobel gradient, direction quantization, suppression and thresholds.
// One register stage. Depends on set_pkg.
`timescale 1ns / 1ps

module set_classify (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  set_pkg::t_win     i_win,
    input  set_pkg::t_tag     i_tag,
    input  set_pkg::t_pix     i_lo,
    input  set_pkg::t_pix     i_hi,
    output logic              o_push,
    output set_pkg::t_res     o_res
);

    logic signed [12:0] gx, gy;
    logic [11:0]        ax, ay;
    logic [12:0]        msum;
    set_pkg::t_pix      mag;

    logic [11:0]   r_ax, r_ay;
    logic          r_same, r_gx_zero, r_gy_zero;
    set_pkg::t_pix r_mag;
    set_pkg::t_win r_win;
    set_pkg::t_tag r_tag;

    function automatic logic signed [12:0] sx(input set_pkg::t_pix v);
        return $signed({3'b000, v});
    endfunction

    always_comb begin
        gx = (sx(i_win[2]) + (sx(i_win[5]) <<< 1) + sx(i_win[8]))
           - (sx(i_win[0]) + (sx(i_win[3]) <<< 1) + sx(i_win[6]));
        gy = (sx(i_win[0]) + (sx(i_win[1]) <<< 1) + sx(i_win[2]))
           - (sx(i_win[6]) + (sx(i_win[7]) <<< 1) + sx(i_win[8]));
        ax = gx[12] ? 12'(-gx) : 12'(gx);
        ay = gy[12] ? 12'(-gy) : 12'(gy);
        msum = {1'b0, ax} + {1'b0, ay};
        mag = (msum > 13'(set_pkg::FULL_SCALE)) ? set_pkg::FULL_SCALE : msum[9:0];
    end

    always_ff @(posedge i_clk) begin
        r_ax      <= ax;
        r_ay      <= ay;
        r_same    <= (gx[12] == gy[12]);
        r_gx_zero <= (gx == '0);
        r_gy_zero <= (gy == '0);
        r_mag     <= mag;
        r_win     <= i_win;
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag <= i_tag;
        end
    end

    logic [21:0]   ty;
    logic [23:0]   p_steep, p_shallow;
    set_pkg::t_dir dir;
    set_pkg::t_pix a, b;
    logic          nb_hi, edge_hit;

    always_comb begin
        ty        = {r_ay, 10'b0};
        p_steep   = r_ax * set_pkg::SLOPE_STEEP_P1;
        p_shallow = r_ax * set_pkg::SLOPE_SHALLOW_P1;
        if (r_gx_zero) begin
            dir = r_gy_zero ? set_pkg::DIR_0 : set_pkg::DIR_90;
        end else if (24'(ty) >= p_steep) begin
            dir = set_pkg::DIR_90;
        end else if (24'(ty) >= p_shallow) begin
            dir = r_same ? set_pkg::DIR_45 : set_pkg::DIR_135;
        end else begin
            dir = set_pkg::DIR_0;
        end

        case (dir)
            set_pkg::DIR_0: begin
                a = r_win[3]; b = r_win[5];
            end
            set_pkg::DIR_45: begin
                a = r_win[6]; b = r_win[2];
            end
            set_pkg::DIR_90: begin
                a = r_win[1]; b = r_win[7];
            end
            default: begin
                a = r_win[0]; b = r_win[8];
            end
        endcase

        nb_hi = (r_win[0] > i_hi) || (r_win[1] > i_hi) || (r_win[2] > i_hi) ||
                (r_win[3] > i_hi) || (r_win[5] > i_hi) ||
                (r_win[6] > i_hi) || (r_win[7] > i_hi) || (r_win[8] > i_hi);

        if (r_mag < a || r_mag < b) begin
            edge_hit = 1'b0;
        end else if (r_mag >= i_hi) begin
            edge_hit = 1'b1;
        end else if (r_mag < i_lo) begin
            edge_hit = 1'b0;
        end else begin
            edge_hit = nb_hi;
        end
    end

    assign o_push      = r_tag.emit;
    assign o_res.value = (r_tag.border || !edge_hit) ? set_pkg::FULL_SCALE : '0;
    assign o_res.last  = r_tag.last;

endmodule

// ===== hw/rtl/set_out_fifo.sv =====
// Result queue between the pipeline and the output channel.
// Depends on set_pkg and set_if.
`timescale 1ns / 1ps

module set_out_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  set_pkg::t_res     i_res,
    set_res_if.source         o_res,
    output logic              o_pop
);

    localparam int FIFO_CW_T = set_pkg::FIFO_CW;

    set_pkg::t_res                 mem [set_pkg::FIFO_DEPTH];
    logic [set_pkg::FIFO_AW-1:0]   r_wptr, r_rptr;
    logic [set_pkg::FIFO_CW-1:0]   r_cnt;

    assign o_res.valid      = (r_cnt != '0);
    assign o_res.edge_value = mem[r_rptr].value;
    assign o_res.frame_last = mem[r_rptr].last;
    assign o_pop            = o_res.valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[r_wptr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) r_wptr <= r_wptr + 1'b1;
            if (o_pop)  r_rptr <= r_rptr + 1'b1;
            r_cnt <= r_cnt + FIFO_CW_T'(i_push) - FIFO_CW_T'(o_pop);
        end
    end

endmodule

// ===== hw/rtl/sobel_edge_threshold.sv =====
// Sobel edge detector with suppression and hysteresis threshold, top level.
// A transaction's tag passes two line buffer registers, the classify register and the result queue.
// Throughput: one transaction per cycle while the result queue has credit.
// Results queue in an 8-entry buffer; input stalls once 8 results are queued or in flight.
// Reset (synchronous, active low) clears counters, window and queue.
// Row memories are not cleared; unwritten entries feed border results only.
`timescale 1ns / 1ps

module sobel_edge_threshold #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    set_pix_if.sink    i_pix,
    set_res_if.source  o_res,
    set_cfg_if.sink    i_cfg
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam int XW = (CW > set_pkg::CFG_DW) ? CW : set_pkg::CFG_DW;
    localparam int XH = (RW > set_pkg::CFG_DW) ? RW : set_pkg::CFG_DW;
    localparam int WD_RST = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
    localparam int HT_RST = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

    logic [CW-1:0] r_wd;
    logic [RW-1:0] r_ht;
    set_pkg::t_pix r_lo, r_hi;
    logic [CW-1:0] r_in_col, r_out_col, n_in_col, n_out_col;
    logic [RW-1:0] r_in_row, r_out_row, n_in_row, n_out_row;
    logic [set_pkg::FIFO_CW-1:0] r_cred;

    logic [XW-1:0] cfg_xw;
    logic [XH-1:0] cfg_xh;
    logic [CW-1:0] wd_cl;
    logic [RW-1:0] ht_cl;
    logic cfg_wr, geo_wr, acc, do_pix, emit, border, last;
    logic push, pop;
    set_pkg::t_tag tag, tag2;
    set_pkg::t_win win;
    set_pkg::t_res res;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr = i_cfg.valid && i_cfg.ready;
    assign geo_wr = cfg_wr && (i_cfg.index == set_pkg::CFG_WIDTH ||
                               i_cfg.index == set_pkg::CFG_HEIGHT);

    assign cfg_xw = XW'(i_cfg.data);
    assign cfg_xh = XH'(i_cfg.data);
    assign wd_cl = (cfg_xw < XW'(3)) ? CW'(3) :
                   (cfg_xw > XW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(cfg_xw);
    assign ht_cl = (cfg_xh < XH'(3)) ? RW'(3) :
                   (cfg_xh > XH'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT) : RW'(cfg_xh);

    assign i_pix.ready = (r_cred < set_pkg::FIFO_CW'(set_pkg::FIFO_DEPTH));
    assign acc = i_pix.valid && i_pix.ready;

    always_comb begin
        do_pix = acc && !i_pix.action && (r_in_row < r_ht);
        emit   = 1'b0;
        if (acc && i_pix.action) begin
            emit = (r_in_row >= r_ht);
        end else if (do_pix) begin
            emit = (r_in_row >= RW'(2)) || (r_in_row == RW'(1) && r_in_col != '0);
        end
        border = (r_out_col == '0) || (r_out_col >= r_wd - CW'(1)) ||
                 (r_out_row == '0) || (r_out_row >= r_ht - RW'(1));
        last   = (r_out_col == r_wd - CW'(1)) && (r_out_row == r_ht - RW'(1));

        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (do_pix) begin
            if (r_in_col + CW'(1) >= r_wd) begin
                n_in_col = '0;
                n_in_row = r_in_row + RW'(1);
            end else begin
                n_in_col = r_in_col + CW'(1);
            end
        end
        if (emit) begin
            if (last) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else if (r_out_col + CW'(1) >= r_wd) begin
                n_out_col = '0;
                n_out_row = r_out_row + RW'(1);
            end else begin
                n_out_col = r_out_col + CW'(1);
            end
        end
        tag.emit   = emit;
        tag.border = border;
        tag.last   = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wd      <= CW'(WD_RST);
            r_ht      <= RW'(HT_RST);
            r_lo      <= '0;
            r_hi      <= set_pkg::FULL_SCALE;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_cred    <= '0;
        end else begin
            r_cred <= r_cred + set_pkg::FIFO_CW'(emit) - set_pkg::FIFO_CW'(pop);
            if (geo_wr) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else begin
                r_in_col  <= n_in_col;
                r_in_row  <= n_in_row;
                r_out_col <= n_out_col;
                r_out_row <= n_out_row;
            end
            if (cfg_wr) begin
                case (i_cfg.index)
                    set_pkg::CFG_WIDTH:  r_wd <= wd_cl;
                    set_pkg::CFG_HEIGHT: r_ht <= ht_cl;
                    set_pkg::CFG_LOW:    r_lo <= i_cfg.data[9:0];
                    set_pkg::CFG_HIGH:   r_hi <= i_cfg.data[9:0];
                    default: ;
                endcase
            end
        end
    end

    set_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (do_pix),
        .i_col   (r_in_col[AW-1:0]),
        .i_px    (i_pix.pixel_value),
        .i_tag   (tag),
        .o_win   (win),
        .o_tag   (tag2)
    );

    set_classify u_classify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_win   (win),
        .i_tag   (tag2),
        .i_lo    (r_lo),
        .i_hi    (r_hi),
        .o_push  (push),
        .o_res   (res)
    );

    set_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (res),
        .o_res   (o_res),
        .o_pop   (pop)
    );

    a_cred_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cred <= set_pkg::FIFO_CW'(set_pkg::FIFO_DEPTH))
        else $error("credit count above queue depth");

    a_pop_has_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> r_cred != '0)
        else $error("result shown without credit");

    a_geo_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        geo_wr |=> (r_in_col == '0 && r_in_row == '0 &&
                    r_out_col == '0 && r_out_row == '0))
        else $error("geometry write did not clear counters");

    a_in_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_col < r_wd)
        else $error("input column out of range");

endmodule
